// ===== sv/iibh_pkg.sv =====
// Package for the integral image and box histogram block.
// Holds sizes, opcodes, error codes, register indexes, the controller state
// type and the command and status structs. Depends on nothing.
package iibh_pkg;

  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 64;
  localparam int NUM_BINS     = 16;
  localparam int NUM_CHANNELS = 3;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 7;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int SUM_W   = 20;
  localparam int RSUM_W  = 14;
  localparam int CNT_W   = 13;
  localparam int RBIN_W  = 7;
  localparam int FRAC_W  = 17;
  localparam int BIN_W   = 4;
  localparam int SEL_W   = 2;
  localparam int CFG_W   = 7;
  localparam int CFG_AW  = 3;
  localparam int STEP_W  = $clog2(FRAC_W);
  localparam int CORNER_W = 2;

  localparam int CH_RAM_W  = NUM_CHANNELS * SUM_W;
  localparam int BIN_RAM_W = NUM_BINS * CNT_W;

  localparam logic [CFG_AW-1:0] REG_COLOUR_MODE     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ENABLE_INTEGRAL = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ENABLE_HIST     = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SUM  = 2'd1,
    OP_HIST = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_BOUNDS = 2'd1,
    ERR_EMPTY  = 2'd2,
    ERR_RSVD   = 2'd3
  } err_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_LD_RD    = 9'b000000010,
    S_LD_WR    = 9'b000000100,
    S_Q_CHK    = 9'b000001000,
    S_Q_RD     = 9'b000010000,
    S_Q_ACC    = 9'b000100000,
    S_DIV_INIT = 9'b001000000,
    S_DIV      = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  typedef struct packed {
    logic ld_start;
    logic ld_read;
    logic ld_write;
    logic q_start;
    logic q_check;
    logic q_read;
    logic q_acc;
    logic div_init;
    logic div_step;
    logic emit;
    logic next_bin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ld_skip;
    logic chk_err;
    logic q_hist;
    logic corner_last;
    logic div_done;
    logic out_free;
    logic more;
  } dp_status_t;

endpackage

// ===== sv/iibh_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the channel tables and the bin tables. Depends on nothing.
module iibh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/iibh_ctrl.sv =====
// Controller state machine for the integral image and box histogram block.
// Sequences loads, corner reads, divisions and result beats. Uses iibh_pkg.
module iibh_ctrl import iibh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_stall,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_opcode))
            OP_LOAD: begin
              cmd.ld_start = 1'b1;
              state_nxt = S_LD_RD;
            end
            OP_SUM, OP_HIST: begin
              cmd.q_start = 1'b1;
              state_nxt = S_Q_CHK;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_RD: begin
        if (st.ld_skip) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.ld_read = 1'b1;
          state_nxt = S_LD_WR;
        end
      end
      S_LD_WR: begin
        cmd.ld_write = 1'b1;
        state_nxt = S_IDLE;
      end
      S_Q_CHK: begin
        cmd.q_check = 1'b1;
        state_nxt = st.chk_err ? S_EMIT : S_Q_RD;
      end
      S_Q_RD: begin
        cmd.q_read = 1'b1;
        state_nxt = S_Q_ACC;
      end
      S_Q_ACC: begin
        cmd.q_acc = 1'b1;
        if (st.corner_last) begin
          state_nxt = st.q_hist ? S_DIV_INIT : S_EMIT;
        end else begin
          state_nxt = S_Q_RD;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.more) begin
            cmd.next_bin = 1'b1;
            state_nxt = S_DIV_INIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== sv/iibh_datapath.sv =====
// Datapath: configuration registers, row sums, table RAMs, corner
// accumulation, serial divider and the output register. Uses iibh_pkg, iibh_ram.
module iibh_datapath import iibh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [1:0]         in_opcode,
  input  logic               in_frame_start,
  input  logic [PIX_W-1:0]   in_pix_c0,
  input  logic [PIX_W-1:0]   in_pix_c1,
  input  logic [PIX_W-1:0]   in_pix_c2,
  input  logic [DIM_W-1:0]   in_x_min,
  input  logic [DIM_W-1:0]   in_y_min,
  input  logic [DIM_W-1:0]   in_x_max,
  input  logic [DIM_W-1:0]   in_y_max,
  input  logic [SEL_W-1:0]   in_channel_sel,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         st,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [SUM_W-1:0]   out_box_sum,
  output logic [BIN_W-1:0]   out_bin_index,
  output logic [CNT_W-1:0]   out_bin_count,
  output logic [FRAC_W-1:0]  out_bin_fraction,
  output logic               out_is_hist,
  output logic               out_last,
  output logic [1:0]         out_error_code
);

  logic             colour_r, en_int_r, en_hist_r;
  logic [DIM_W-1:0] width_r, height_r, eff_w, eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r  <= 1'b0;
      width_r   <= DIM_W'(MAX_WIDTH);
      height_r  <= DIM_W'(MAX_HEIGHT);
      en_int_r  <= 1'b1;
      en_hist_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COLOUR_MODE:     colour_r  <= cfg_wdata[0];
        REG_IMAGE_WIDTH:     width_r   <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    height_r  <= cfg_wdata[DIM_W-1:0];
        REG_ENABLE_INTEGRAL: en_int_r  <= cfg_wdata[0];
        REG_ENABLE_HIST:     en_hist_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = width_r;
    if (width_r == '0) eff_w = DIM_W'(1);
    else if (width_r > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
    eff_h = height_r;
    if (height_r == '0) eff_h = DIM_W'(1);
    else if (height_r > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
  end

  // Table RAMs: one row per interior table entry, all channels or bins side by side.
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [CH_RAM_W-1:0]  ch_wdata, ch_rdata;
  logic [BIN_RAM_W-1:0] bin_wdata, bin_rdata;

  iibh_ram #(.WIDTH(CH_RAM_W), .DEPTH(DEPTH)) u_ch_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(ch_wdata),
    .re(ram_re), .raddr(raddr), .rdata(ch_rdata)
  );

  iibh_ram #(.WIDTH(BIN_RAM_W), .DEPTH(DEPTH)) u_bin_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(bin_wdata),
    .re(ram_re), .raddr(raddr), .rdata(bin_rdata)
  );

  // Load path.
  logic [COL_W-1:0]  col_r;
  logic [DIM_W-1:0]  row_r;
  logic [PIX_W-1:0]  pix_r [NUM_CHANNELS];
  logic [RSUM_W-1:0] rs_ch_r [NUM_CHANNELS];
  logic [RSUM_W-1:0] rs_ch_nxt [NUM_CHANNELS];
  logic [RBIN_W-1:0] rs_bin_r [NUM_BINS];
  logic [RBIN_W-1:0] rs_bin_nxt [NUM_BINS];
  logic [BIN_W-1:0]  bin_sel;
  logic [COL_W-1:0]  c_s;
  logic [DIM_W-1:0]  r_s, col_inc;
  logic              clr_s, wrap_w;

  always_comb begin
    c_s = in_frame_start ? '0 : col_r;
    r_s = in_frame_start ? '0 : row_r;
    clr_s = in_frame_start;
    if (DIM_W'(c_s) >= eff_w) begin
      c_s = '0;
      r_s = r_s + 1'b1;
      clr_s = 1'b1;
    end
  end

  assign bin_sel = pix_r[0][PIX_W-1 -: BIN_W];
  assign col_inc = DIM_W'(col_r) + 1'b1;
  assign wrap_w  = (col_inc >= eff_w);

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      rs_ch_nxt[c] = rs_ch_r[c] + RSUM_W'(pix_r[c]);
      ch_wdata[c*SUM_W +: SUM_W] =
        ((row_r == '0) ? '0 : ch_rdata[c*SUM_W +: SUM_W]) + SUM_W'(rs_ch_nxt[c]);
    end
    for (int b = 0; b < NUM_BINS; b++) begin
      rs_bin_nxt[b] = rs_bin_r[b] + RBIN_W'(bin_sel == BIN_W'(b));
      bin_wdata[b*CNT_W +: CNT_W] =
        ((row_r == '0) ? '0 : bin_rdata[b*CNT_W +: CNT_W]) + CNT_W'(rs_bin_nxt[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) rs_ch_r[c] <= '0;
      for (int b = 0; b < NUM_BINS; b++) rs_bin_r[b] <= '0;
    end else if (cmd.ld_start) begin
      col_r <= c_s;
      row_r <= r_s;
      if (clr_s) begin
        for (int c = 0; c < NUM_CHANNELS; c++) rs_ch_r[c] <= '0;
        for (int b = 0; b < NUM_BINS; b++) rs_bin_r[b] <= '0;
      end
    end else if (cmd.ld_write) begin
      if (wrap_w) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
        for (int c = 0; c < NUM_CHANNELS; c++) rs_ch_r[c] <= '0;
        for (int b = 0; b < NUM_BINS; b++) rs_bin_r[b] <= '0;
      end else begin
        col_r <= col_inc[COL_W-1:0];
        for (int c = 0; c < NUM_CHANNELS; c++) rs_ch_r[c] <= rs_ch_nxt[c];
        for (int b = 0; b < NUM_BINS; b++) rs_bin_r[b] <= rs_bin_nxt[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_start) begin
      pix_r[0] <= in_pix_c0;
      pix_r[1] <= in_pix_c1;
      pix_r[2] <= in_pix_c2;
    end
  end

  assign st.ld_skip = (row_r >= eff_h);

  // Query path.
  op_t               op_r;
  err_t              err_r, err_c;
  logic [DIM_W-1:0]  x0_r, y0_r, x1_r, y1_r, cx, cy;
  logic [SEL_W-1:0]  sel_r, chans;
  logic [CNT_W-1:0]  area_r;
  logic [CORNER_W-1:0] corner_r;
  logic              czero_r, csub_r;
  logic [SUM_W-1:0]  sum_acc_r, ch_val;
  logic [CNT_W-1:0]  bin_acc_r [NUM_BINS];
  logic [BIN_W-1:0]  bin_r;

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      op_r  <= op_t'(in_opcode);
      x0_r  <= in_x_min;
      y0_r  <= in_y_min;
      x1_r  <= in_x_max;
      y1_r  <= in_y_max;
      sel_r <= in_channel_sel;
    end
  end

  assign chans = colour_r ? SEL_W'(NUM_CHANNELS) : SEL_W'(1);

  always_comb begin
    err_c = ERR_OK;
    if (x1_r > eff_w || y1_r > eff_h) err_c = ERR_BOUNDS;
    else if (x0_r >= x1_r || y0_r >= y1_r) err_c = ERR_EMPTY;
    else if (op_r == OP_SUM && (!en_int_r || sel_r >= chans)) err_c = ERR_EMPTY;
    else if (op_r == OP_HIST && !en_hist_r) err_c = ERR_EMPTY;
  end

  assign st.chk_err = (err_c != ERR_OK);
  assign st.q_hist  = (op_r == OP_HIST);

  // Corners in order: top-left and bottom-right add, bottom-left and top-right subtract.
  assign cx = (corner_r == 2'd0 || corner_r == 2'd2) ? x0_r : x1_r;
  assign cy = (corner_r == 2'd0 || corner_r == 2'd3) ? y0_r : y1_r;
  assign st.corner_last = (corner_r == 2'd3);

  always_comb begin
    ch_val = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (sel_r == SEL_W'(c)) ch_val = ch_rdata[c*SUM_W +: SUM_W];
    end
    if (czero_r) ch_val = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.q_check) begin
      err_r    <= err_c;
      area_r   <= CNT_W'((x1_r - x0_r) * (y1_r - y0_r));
      corner_r <= '0;
      sum_acc_r <= '0;
      for (int b = 0; b < NUM_BINS; b++) bin_acc_r[b] <= '0;
    end
    if (cmd.q_read) begin
      czero_r <= (cx == '0 || cy == '0);
      csub_r  <= corner_r[1];
    end
    if (cmd.q_acc) begin
      corner_r <= corner_r + 1'b1;
      sum_acc_r <= csub_r ? sum_acc_r - ch_val : sum_acc_r + ch_val;
      for (int b = 0; b < NUM_BINS; b++) begin
        if (!czero_r) begin
          bin_acc_r[b] <= csub_r ? bin_acc_r[b] - bin_rdata[b*CNT_W +: CNT_W]
                                 : bin_acc_r[b] + bin_rdata[b*CNT_W +: CNT_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= '0;
    end else if (cmd.q_check) begin
      bin_r <= '0;
    end else if (cmd.next_bin) begin
      bin_r <= bin_r + 1'b1;
    end
  end

  assign ram_we = cmd.ld_write;
  assign ram_re = cmd.ld_read | cmd.q_read;
  assign waddr  = {row_r[ROW_W-1:0], col_r};

  always_comb begin
    if (cmd.q_read) begin
      raddr = {ROW_W'(cy - 1'b1), COL_W'(cx - 1'b1)};
    end else begin
      raddr = {ROW_W'(row_r - 1'b1), col_r};
    end
  end

  // Restoring divider, one quotient bit a cycle. The count is below twice the
  // area unless saturated, so the quotient fits the fraction width.
  logic [CNT_W-1:0]  cnt_sel, rem_r;
  logic [FRAC_W-1:0] dq_r, q_r;
  logic [STEP_W-1:0] step_r;
  logic              sat_r, qbit;
  logic [CNT_W:0]    trial;

  assign cnt_sel = bin_acc_r[bin_r];
  assign trial   = {rem_r, dq_r[FRAC_W-1]};
  assign qbit    = (trial >= {1'b0, area_r});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      sat_r  <= ({1'b0, cnt_sel} >= {area_r, 1'b0});
      rem_r  <= cnt_sel >> 1;
      dq_r   <= {cnt_sel[0], {(FRAC_W-1){1'b0}}};
      q_r    <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= qbit ? CNT_W'(trial - {1'b0, area_r}) : CNT_W'(trial);
      dq_r   <= dq_r << 1;
      q_r    <= {q_r[FRAC_W-2:0], qbit};
      step_r <= step_r + 1'b1;
    end
  end

  assign st.div_done = (step_r == STEP_W'(FRAC_W - 1));

  // Output register.
  logic out_valid_r;

  assign st.out_free = !out_valid_r || !out_stall;
  assign st.more = (err_r == ERR_OK) && (op_r == OP_HIST) &&
                   (bin_r != BIN_W'(NUM_BINS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_box_sum      <= '0;
      out_bin_index    <= '0;
      out_bin_count    <= '0;
      out_bin_fraction <= '0;
      out_is_hist      <= (op_r == OP_HIST);
      out_last         <= 1'b1;
      out_error_code   <= err_r;
      if (err_r == ERR_OK) begin
        if (op_r == OP_HIST) begin
          out_bin_index    <= bin_r;
          out_bin_count    <= cnt_sel;
          out_bin_fraction <= sat_r ? '1 : q_r;
          out_last         <= (bin_r == BIN_W'(NUM_BINS - 1));
        end else begin
          out_box_sum <= sum_acc_r;
        end
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/integral_image_box_histogram.sv =====
// Top level of the integral image and box histogram block.
// Joins the controller and the datapath. Uses iibh_pkg, iibh_ctrl, iibh_datapath.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  opcode, frame_start, pixels, rectangle, channel
//   out      out_valid/out_stall  box sum or one histogram bin, last, error
//   cfg      cfg_we               cfg_addr, cfg_wdata
//
// A pixel load steps through accept, read of the entry above, and write.
// A sum query runs a check and four corner reads, each a read and an accumulate step.
// A histogram query adds, for each bin, a set-up and a full pass of the serial divider.
// Errors return one beat after the check. Reset is synchronous and needs no clearing pass.
// A stalled result holds the block in its emit step; the next item waits for it.
module integral_image_box_histogram import iibh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic              in_frame_start,
  input  logic [PIX_W-1:0]  in_pix_c0,
  input  logic [PIX_W-1:0]  in_pix_c1,
  input  logic [PIX_W-1:0]  in_pix_c2,
  input  logic [DIM_W-1:0]  in_x_min,
  input  logic [DIM_W-1:0]  in_y_min,
  input  logic [DIM_W-1:0]  in_x_max,
  input  logic [DIM_W-1:0]  in_y_max,
  input  logic [SEL_W-1:0]  in_channel_sel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SUM_W-1:0]  out_box_sum,
  output logic [BIN_W-1:0]  out_bin_index,
  output logic [CNT_W-1:0]  out_bin_count,
  output logic [FRAC_W-1:0] out_bin_fraction,
  output logic              out_is_hist,
  output logic              out_last,
  output logic [1:0]        out_error_code
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  iibh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_opcode(in_opcode),
    .in_stall(in_stall), .st(st), .cmd(cmd)
  );

  iibh_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_opcode(in_opcode), .in_frame_start(in_frame_start),
    .in_pix_c0(in_pix_c0), .in_pix_c1(in_pix_c1), .in_pix_c2(in_pix_c2),
    .in_x_min(in_x_min), .in_y_min(in_y_min), .in_x_max(in_x_max),
    .in_y_max(in_y_max), .in_channel_sel(in_channel_sel),
    .cmd(cmd), .st(st),
    .out_stall(out_stall), .out_valid(out_valid),
    .out_box_sum(out_box_sum), .out_bin_index(out_bin_index),
    .out_bin_count(out_bin_count), .out_bin_fraction(out_bin_fraction),
    .out_is_hist(out_is_hist), .out_last(out_last),
    .out_error_code(out_error_code)
  );

endmodule

// ===== sv/iibh_checker.sv =====
// Port-level checker for the integral image and box histogram block,
// bound to the top level. Uses iibh_pkg.
module iibh_checker import iibh_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SUM_W-1:0]  out_box_sum,
  input logic [BIN_W-1:0]  out_bin_index,
  input logic [CNT_W-1:0]  out_bin_count,
  input logic              out_is_hist,
  input logic              out_last,
  input logic [1:0]        out_error_code
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_OK |-> out_last)
    else $error("error beat without last");

  a_sum_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_hist |-> out_last && out_bin_count == '0 && out_bin_index == '0)
    else $error("sum beat carries histogram fields");

  a_hist_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_hist && out_error_code == ERR_OK |->
      (out_last == (out_bin_index == BIN_W'(NUM_BINS - 1))) && out_box_sum == '0)
    else $error("histogram beat last flag does not match bin");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_box_sum) &&
      $stable(out_bin_count))
    else $error("stalled result beat changed");

endmodule

bind integral_image_box_histogram iibh_checker u_iibh_checker (.*);

// ===== tb/iibh_box_hist_checker.sv =====
// Checker for the integral image and box histogram block.
// Watches the configuration port and both channels, predicts every result beat and
// compares it with the block's output. Depends on iibh_pkg.
`timescale 1ns / 100ps
module iibh_box_hist_checker import iibh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic              in_frame_start,
  input  logic [PIX_W-1:0]  in_pix_c0,
  input  logic [PIX_W-1:0]  in_pix_c1,
  input  logic [PIX_W-1:0]  in_pix_c2,
  input  logic [DIM_W-1:0]  in_x_min,
  input  logic [DIM_W-1:0]  in_y_min,
  input  logic [DIM_W-1:0]  in_x_max,
  input  logic [DIM_W-1:0]  in_y_max,
  input  logic [SEL_W-1:0]  in_channel_sel,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [SUM_W-1:0]  out_box_sum,
  input  logic [BIN_W-1:0]  out_bin_index,
  input  logic [CNT_W-1:0]  out_bin_count,
  input  logic [FRAC_W-1:0] out_bin_fraction,
  input  logic              out_is_hist,
  input  logic              out_last,
  input  logic [1:0]        out_error_code,
  output int                failures,
  output int                pending
);

  localparam int TW    = MAX_WIDTH + 1;
  localparam int TSIZE = TW * (MAX_HEIGHT + 1);

  typedef struct packed {
    logic [SUM_W-1:0]  box_sum;
    logic [BIN_W-1:0]  bin_index;
    logic [CNT_W-1:0]  bin_count;
    logic [FRAC_W-1:0] bin_fraction;
    logic              is_hist;
    logic              last;
    logic [1:0]        error_code;
  } beat_t;

  logic [SUM_W-1:0]  chan_sat [NUM_CHANNELS][TSIZE];
  logic [CNT_W-1:0]  bin_sat [NUM_BINS][TSIZE];
  logic [RSUM_W-1:0] row_chan [NUM_CHANNELS];
  logic [RBIN_W-1:0] row_bin [NUM_BINS];
  int                col_pos;
  int                row_pos;
  logic              colour;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic              en_integral;
  logic              en_hist;
  beat_t             expected_beats[$];

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic queue_beat(beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endtask

  task automatic clear_rows();
    for (int c = 0; c < NUM_CHANNELS; c++) row_chan[c] = '0;
    for (int b = 0; b < NUM_BINS; b++) row_bin[b] = '0;
  endtask

  task automatic reset_model();
    for (int i = 0; i < TSIZE; i++) begin
      for (int c = 0; c < NUM_CHANNELS; c++) chan_sat[c][i] = '0;
      for (int b = 0; b < NUM_BINS; b++) bin_sat[b][i] = '0;
    end
    clear_rows();
    col_pos = 0;
    row_pos = 0;
    colour = 1'b0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    en_integral = 1'b1;
    en_hist = 1'b1;
  endtask

  task automatic predict_load(logic fs, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    int w, h, base, above, bin;
    logic [7:0] px [3];
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    px[0] = c0;
    px[1] = c1;
    px[2] = c2;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      clear_rows();
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      clear_rows();
    end
    if (row_pos >= h) return;
    base = (row_pos + 1) * TW + col_pos + 1;
    above = row_pos * TW + col_pos + 1;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      row_chan[c] = row_chan[c] + px[c];
      chan_sat[c][base] = chan_sat[c][above] + row_chan[c];
    end
    bin = c0 >> 4;
    for (int b = 0; b < NUM_BINS; b++) begin
      if (b == bin) row_bin[b] = row_bin[b] + 1'b1;
      bin_sat[b][base] = bin_sat[b][above] + row_bin[b];
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      clear_rows();
    end
  endtask

  task automatic predict_query(logic [1:0] op, int x0, int y0, int x1, int y1, int sel);
    beat_t r;
    err_t e;
    int chans, i00, i11, i10, i01, area;
    logic [CNT_W-1:0] cnt;
    logic [31:0] frac;
    chans = colour ? 3 : 1;
    e = ERR_OK;
    if (x1 > clamp_dim(width_reg, MAX_WIDTH) || y1 > clamp_dim(height_reg, MAX_HEIGHT))
      e = ERR_BOUNDS;
    else if (x0 >= x1 || y0 >= y1)
      e = ERR_EMPTY;
    else if (op == OP_SUM && (!en_integral || sel >= chans))
      e = ERR_EMPTY;
    else if (op == OP_HIST && !en_hist)
      e = ERR_EMPTY;
    r = '0;
    if (e != ERR_OK) begin
      r.is_hist = (op == OP_HIST);
      r.last = 1'b1;
      r.error_code = e;
      queue_beat(r);
      return;
    end
    i00 = y0 * TW + x0;
    i11 = y1 * TW + x1;
    i10 = y1 * TW + x0;
    i01 = y0 * TW + x1;
    if (op == OP_SUM) begin
      r.box_sum = chan_sat[sel][i00] + chan_sat[sel][i11] - chan_sat[sel][i10]
                  - chan_sat[sel][i01];
      r.last = 1'b1;
      queue_beat(r);
    end else begin
      area = (x1 - x0) * (y1 - y0);
      for (int b = 0; b < NUM_BINS; b++) begin
        cnt = bin_sat[b][i00] + bin_sat[b][i11] - bin_sat[b][i10] - bin_sat[b][i01];
        frac = (32'(cnt) << 16) / area;
        if (frac > 32'h1FFFF) frac = 32'h1FFFF;
        r.bin_index = BIN_W'(b);
        r.bin_count = cnt;
        r.bin_fraction = frac[FRAC_W-1:0];
        r.is_hist = 1'b1;
        r.last = (b == NUM_BINS - 1);
        queue_beat(r);
      end
    end
  endtask

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst_n) begin
      reset_model();
      expected_beats.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_COLOUR_MODE:     colour = cfg_wdata[0];
          REG_IMAGE_WIDTH:     width_reg = cfg_wdata;
          REG_IMAGE_HEIGHT:    height_reg = cfg_wdata;
          REG_ENABLE_INTEGRAL: en_integral = cfg_wdata[0];
          REG_ENABLE_HIST:     en_hist = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_box_sum, out_bin_index, out_bin_count, out_bin_fraction,
               out_is_hist, out_last, out_error_code};
        if (expected_beats.size() == 0) begin
          failures++;
          $display("%0t: unexpected result beat %h", $time, got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            failures++;
            $display("%0t: mismatch sum exp %0d act %0d, bin exp %0d act %0d, cnt exp %0d act %0d",
                     $time, want.box_sum, got.box_sum, want.bin_index, got.bin_index,
                     want.bin_count, got.bin_count);
            $display("%0t: frac exp %0d act %0d, hist exp %b act %b, last exp %b act %b, err exp %0d act %0d",
                     $time, want.bin_fraction, got.bin_fraction, want.is_hist, got.is_hist,
                     want.last, got.last, want.error_code, got.error_code);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_opcode)
          OP_LOAD: predict_load(in_frame_start, in_pix_c0, in_pix_c1, in_pix_c2);
          OP_SUM, OP_HIST: predict_query(in_opcode, in_x_min, in_y_min, in_x_max, in_y_max,
                                         in_channel_sel);
          default: ;
        endcase
      end
    end
    pending = expected_beats.size();
  end

endmodule

// ===== tb/tb_integral_image_box_histogram.sv =====
// Top of the testbench for the integral image and box histogram block.
// Drives configuration, pixel frames and queries with random gaps and stalls; the checker
// predicts and compares. Depends on iibh_pkg, iibh_box_hist_checker and the block.
`timescale 1ns / 100ps
module tb_integral_image_box_histogram;
  import iibh_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode = OP_NONE;
  logic              in_frame_start = 1'b0;
  logic [PIX_W-1:0]  in_pix_c0 = '0;
  logic [PIX_W-1:0]  in_pix_c1 = '0;
  logic [PIX_W-1:0]  in_pix_c2 = '0;
  logic [DIM_W-1:0]  in_x_min = '0;
  logic [DIM_W-1:0]  in_y_min = '0;
  logic [DIM_W-1:0]  in_x_max = '0;
  logic [DIM_W-1:0]  in_y_max = '0;
  logic [SEL_W-1:0]  in_channel_sel = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SUM_W-1:0]  out_box_sum;
  logic [BIN_W-1:0]  out_bin_index;
  logic [CNT_W-1:0]  out_bin_count;
  logic [FRAC_W-1:0] out_bin_fraction;
  logic              out_is_hist;
  logic              out_last;
  logic [1:0]        out_error_code;
  int                failures;
  int                pending;
  logic              calm = 1'b0;
  logic              hold_req = 1'b0;
  int                items = 0;
  int                img_w = 64;
  int                img_h = 64;

  always #5 clk = ~clk;

  integral_image_box_histogram uut (.*);

  iibh_box_hist_checker checker_i (.*);

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  always begin
    @(negedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (400) @(negedge clk);
      hold_req = 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 18);
    end
  end

  task automatic send(logic [1:0] op, int fs, int c0, int c1,
                      int c2, int x0, int y0, int x1, int y1, int sel);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_opcode <= op;
    in_frame_start <= fs[0];
    in_pix_c0 <= PIX_W'(c0);
    in_pix_c1 <= PIX_W'(c1);
    in_pix_c2 <= PIX_W'(c2);
    in_x_min <= DIM_W'(x0);
    in_y_min <= DIM_W'(y0);
    in_x_max <= DIM_W'(x1);
    in_y_max <= DIM_W'(y1);
    in_channel_sel <= SEL_W'(sel);
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items++;
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic configure(int colour, int w, int h, int ei, int eh);
    drain();
    cfg_write(REG_COLOUR_MODE, colour);
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
    cfg_write(REG_ENABLE_INTEGRAL, ei);
    cfg_write(REG_ENABLE_HIST, eh);
    img_w = w;
    img_h = h;
  endtask

  task automatic load_frame(bit saturate);
    for (int i = 0; i < img_w * img_h; i++) begin
      if (saturate)
        send(OP_LOAD, i == 0, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 0, 0);
      else
        send(OP_LOAD, i == 0, $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 64), $urandom_range(0, 64),
             $urandom_range(0, 64), $urandom_range(0, 64), $urandom_range(0, 2));
    end
  endtask

  task automatic random_query();
    int x0, y0, x1, y1, kind;
    logic [1:0] op;
    op = $urandom_range(0, 2) == 0 ? OP_HIST : OP_SUM;
    x0 = $urandom_range(0, img_w - 1);
    x1 = $urandom_range(x0 + 1, img_w);
    y0 = $urandom_range(0, img_h - 1);
    y1 = $urandom_range(y0 + 1, img_h);
    kind = $urandom_range(0, 9);
    if (kind == 0 && img_w < 64) x1 = $urandom_range(img_w + 1, 64);
    if (kind == 1 && img_h < 64) y1 = $urandom_range(img_h + 1, 64);
    if (kind == 2) y0 = y1;
    if (kind == 3) x0 = x1 + $urandom_range(0, 1);
    if (kind == 4) begin
      send(OP_NONE, $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 255), x0, y0, x1, y1, $urandom_range(0, 2));
    end else if (kind == 5) begin
      send(OP_LOAD, 1'b0, $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 255), x0, y0, x1, y1, $urandom_range(0, 2));
    end else begin
      send(op, $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 255), x0, y0, x1, y1, $urandom_range(0, 2));
    end
  endtask

  initial begin
    int w, h, phase;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    configure(1, 2, 2, 1, 1);
    send(OP_LOAD, 1'b1, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 0, 0);
    send(OP_LOAD, 1'b0, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0);
    send(OP_LOAD, 1'b0, 8'h0F, 8'h10, 8'hF0, 0, 0, 0, 0, 0);
    send(OP_LOAD, 1'b0, 8'h80, 8'h7F, 8'h01, 0, 0, 0, 0, 0);
    send(OP_LOAD, 1'b0, 8'hAA, 8'h55, 8'hAA, 0, 0, 0, 0, 0);
    for (int c = 0; c < 3; c++) send(OP_SUM, 1'b0, 0, 0, 0, 0, 0, 2, 2, c);
    send(OP_HIST, 1'b1, 0, 0, 0, 0, 0, 2, 2, 0);
    send(OP_HIST, 1'b0, 0, 0, 0, 1, 1, 2, 2, 0);
    send(OP_SUM, 1'b0, 0, 0, 0, 0, 0, 64, 1, 0);
    send(OP_HIST, 1'b0, 0, 0, 0, 0, 0, 1, 3, 0);
    send(OP_SUM, 1'b0, 0, 0, 0, 1, 0, 1, 2, 1);
    send(OP_HIST, 1'b0, 0, 0, 0, 0, 2, 2, 2, 0);
    send(OP_SUM, 1'b0, 0, 0, 0, 0, 0, 2, 2, 3);
    send(OP_NONE, 1'b1, 8'hFF, 8'hFF, 8'hFF, 64, 64, 64, 64, 3);
    send(OP_LOAD, 1'b1, 8'h12, 8'h34, 8'h56, 0, 0, 0, 0, 0);
    send(OP_LOAD, 1'b0, 8'hE0, 8'h01, 8'h02, 0, 0, 0, 0, 0);
    send(OP_LOAD, 1'b0, 8'h40, 8'h03, 8'h04, 0, 0, 0, 0, 0);
    configure(1, 1, 2, 0, 0);
    send(OP_LOAD, 1'b0, 8'h99, 8'h99, 8'h99, 0, 0, 0, 0, 0);
    send(OP_SUM, 1'b0, 0, 0, 0, 0, 0, 1, 2, 0);
    send(OP_HIST, 1'b0, 0, 0, 0, 0, 0, 1, 2, 0);
    configure(0, 2, 2, 1, 1);
    send(OP_SUM, 1'b0, 0, 0, 0, 0, 0, 2, 2, 1);
    send(OP_SUM, 1'b0, 0, 0, 0, 0, 0, 2, 2, 0);

    phase = 0;
    items = 0;
    while (items < 260) begin
      case ($urandom_range(0, 7))
        0: begin w = 1; h = $urandom_range(1, 4); end
        1: begin w = 64; h = 1; end
        2: begin w = 1; h = 64; end
        default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
      endcase
      if (phase == 3) begin
        w = 8;
        h = 8;
      end
      configure($urandom_range(0, 1), w, h, $urandom_range(0, 5) != 0,
                $urandom_range(0, 5) != 0);
      calm = (phase == 3);
      load_frame(1'b0);
      if (phase == 2) hold_req = 1'b1;
      repeat ($urandom_range(3, 8)) random_query();
      calm = 1'b0;
      phase++;
    end

    configure(1, 8, 8, 1, 1);
    load_frame(1'b1);
    for (int c = 0; c < 3; c++) send(OP_SUM, 1'b0, 0, 0, 0, 0, 0, 8, 8, c);
    send(OP_HIST, 1'b0, 0, 0, 0, 0, 0, 8, 8, 0);
    send(OP_HIST, 1'b0, 0, 0, 0, 7, 7, 8, 8, 0);
    repeat (4) random_query();

    drain();
    if (failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
